[rtl/ccps_pkg.sv]
// package for the cylinder cutoff pair scan core: widths, codes, shared types
// no dependencies
package ccps_pkg;
  localparam int MaxAtomsDefault  = 1024;
  localparam int CoordBitsDefault = 24;
  localparam int SlotW  = 10;
  localparam int CountW = 11;
  localparam int LimSqW = 50;
  localparam int AxLimW = 24;
  localparam int FoundW = 20;
  localparam int CloseW = 19;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 50;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LIST_MODE  = 3'd0,
    REG_FIRST_CNT  = 3'd1,
    REG_SECOND_CNT = 3'd2,
    REG_AXIS       = 3'd3,
    REG_RAD_LIM    = 3'd4,
    REG_AX_LIM     = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_TRI   = 2'd0,
    MODE_CROSS = 2'd1,
    MODE_INDEX = 2'd2
  } list_mode_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;
endpackage

[rtl/ccps_if.sv]
// valid/ready channel interfaces for the pair scan core
// depends on ccps_pkg
interface ccps_in_if import ccps_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic op;
  logic [SlotW-1:0] slot;
  logic signed [CoordBitsDefault-1:0] pos_x;
  logic signed [CoordBitsDefault-1:0] pos_y;
  logic signed [CoordBitsDefault-1:0] pos_z;
  modport source (output valid, op, slot, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, op, slot, pos_x, pos_y, pos_z, output ready);
endinterface

interface ccps_out_if import ccps_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  logic [SlotW-1:0] first_index;
  logic [SlotW-1:0] second_index;
  logic is_close;
  logic last_pair;
  logic [CloseW-1:0] close_count;
  modport source (output valid, first_index, second_index, is_close, last_pair,
                  close_count, input ready);
  modport sink (input valid, first_index, second_index, is_close, last_pair,
                close_count, output ready);
endinterface

[rtl/ccps_front.sv]
// front end: accepts requests, writes loads into the position store,
// walks the pair scan and queues pair jobs; depends on ccps_pkg
module ccps_front import ccps_pkg::*; #(
  parameter int MaxAtoms = MaxAtomsDefault,
  parameter int AddrW = $clog2(MaxAtoms)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_op,
  input  logic [SlotW-1:0] in_slot,
  input  logic [1:0] list_mode,
  input  logic [CountW-1:0] first_count,
  input  logic [CountW-1:0] second_count,
  input  logic restart,
  input  logic restart_tri,
  input  logic queue_empty,
  output logic load_en,
  output logic [AddrW-1:0] load_addr,
  output logic job_valid,
  input  logic job_ready,
  output logic [AddrW-1:0] job_a,
  output logic [AddrW-1:0] job_b,
  output logic job_last
);
  localparam int CW = AddrW + 1;
  localparam logic [CW-1:0] MaxC = CW'(MaxAtoms);

  logic [CW-1:0] outer_counter, inner_counter;
  logic [CW-1:0] outer_next, inner_next;
  logic [CW-1:0] n0, n1, room, pcnt, b_full;
  logic [CountW:0] fc_w, sc_w;
  logic [1:0] mode;
  logic empty, last, eval_req, load_fits;

  always_comb begin
    mode = (list_mode == 2'd3) ? MODE_TRI : list_mode;
    fc_w = {1'b0, first_count};
    sc_w = {1'b0, second_count};
    n0 = (fc_w > (CountW+1)'(MaxAtoms)) ? MaxC : CW'(first_count);
    room = MaxC - n0;
    n1 = ((CountW+1)'(second_count) > (CountW+1)'(room)) ? room : CW'(sc_w);
    pcnt = (n0 < n1) ? n0 : n1;
    empty = 1'b0;
    last = 1'b0;
    b_full = inner_counter;
    case (mode)
      MODE_CROSS: begin
        empty = (n0 == '0) || (n1 == '0);
        b_full = n0 + inner_counter;
        last = (outer_counter == n0 - 1'b1) && (inner_counter == n1 - 1'b1);
      end
      MODE_INDEX: begin
        empty = (pcnt == '0);
        b_full = n0 + outer_counter;
        last = (outer_counter == pcnt - 1'b1);
      end
      default: begin
        empty = (n0 < CW'(2));
        last = (outer_counter == n0 - CW'(2)) && (inner_counter == n0 - 1'b1);
      end
    endcase
  end

  // a load waits until every queued pair has read the store
  assign in_ready = (in_op == OP_EVAL) ? job_ready : queue_empty;
  assign eval_req = in_valid && in_ready && (in_op == OP_EVAL);
  assign load_fits = (CountW+1)'(in_slot) < (CountW+1)'(MaxAtoms);
  assign load_en = in_valid && in_ready && (in_op == OP_LOAD) && load_fits;
  assign load_addr = AddrW'(in_slot);

  assign job_valid = eval_req && !empty;
  assign job_a = outer_counter[AddrW-1:0];
  assign job_b = b_full[AddrW-1:0];
  assign job_last = last;

  always_comb begin
    outer_next = outer_counter;
    inner_next = inner_counter;
    if (last) begin
      outer_next = '0;
      inner_next = (mode == MODE_TRI) ? CW'(1) : '0;
    end else begin
      case (mode)
        MODE_CROSS: begin
          if (inner_counter + 1'b1 >= n1) begin
            inner_next = '0;
            outer_next = outer_counter + 1'b1;
          end else begin
            inner_next = inner_counter + 1'b1;
          end
        end
        MODE_INDEX: outer_next = outer_counter + 1'b1;
        default: begin
          if (inner_counter + 1'b1 >= n0) begin
            outer_next = outer_counter + 1'b1;
            inner_next = outer_counter + CW'(2);
          end else begin
            inner_next = inner_counter + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      outer_counter <= '0;
      inner_counter <= restart_tri ? CW'(1) : '0;
    end else if (job_valid) begin
      outer_counter <= outer_next;
      inner_counter <= inner_next;
    end
  end
endmodule

[rtl/ccps_queue.sv]
// small fifo holding pair jobs between front and back end
// depends on ccps_pkg
module ccps_queue import ccps_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output logic [Width-1:0] rd_data
);
  localparam int PW = $clog2(Depth);
  logic [Width-1:0] mem [Depth];
  logic [PW-1:0] wp, rp;
  logic [PW:0] cnt;
  logic wr, rd;

  assign wr_ready = cnt != (PW+1)'(Depth);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= (wp == PW'(Depth-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == PW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (PW+1)'(wr) - (PW+1)'(rd);
    end
  end
endmodule

[rtl/ccps_back.sv]
// back end: reads both positions from the dual-read store, squares the
// radial components, compares with limits and counts; depends on ccps_pkg
module ccps_back import ccps_pkg::*; #(
  parameter int MaxAtoms = MaxAtomsDefault,
  parameter int CoordBits = CoordBitsDefault,
  parameter int AddrW = $clog2(MaxAtoms)
) (
  input  logic clk,
  input  logic rst,
  input  logic load_en,
  input  logic [AddrW-1:0] load_addr,
  input  logic [CoordBits-1:0] load_x,
  input  logic [CoordBits-1:0] load_y,
  input  logic [CoordBits-1:0] load_z,
  input  logic [1:0] axis_select,
  input  logic [LimSqW-1:0] radial_limit_sq,
  input  logic [AxLimW-1:0] axial_limit,
  input  logic restart,
  input  logic job_valid,
  output logic job_ready,
  input  logic [AddrW-1:0] job_a,
  input  logic [AddrW-1:0] job_b,
  input  logic job_last,
  output logic res_valid,
  input  logic res_ready,
  output logic [SlotW-1:0] res_first_index,
  output logic [SlotW-1:0] res_second_index,
  output logic res_is_close,
  output logic res_last_pair,
  output logic [CloseW-1:0] res_close_count
);
  localparam int W3 = 3 * CoordBits;
  localparam int DW = CoordBits + 1;
  localparam int MW = 26;

  logic [W3-1:0] mem [MaxAtoms];
  logic [W3-1:0] rd_a, rd_b;

  // stage valids and payload
  logic s1_v, s2_v, s3_v;
  logic [AddrW-1:0] s1_a, s1_b, s2_a, s2_b, s3_a, s3_b;
  logic s1_l, s2_l, s3_l;
  logic s2_ovf;
  logic [MW-1:0] s2_m1, s2_m2;
  logic [DW-1:0] s2_axd;
  logic [2*MW-1:0] s3_sq1, s3_sq2;
  logic s3_ax_ok, s3_ovf;
  logic [FoundW-1:0] found_count, found_next;
  logic close;
  logic advance;

  logic signed [DW-1:0] dx, dy, dz, dr1, dr2, dax;
  logic [DW-1:0] m1, m2, axm;
  logic [1:0] ax;

  // pipeline moves as one; output register at the end
  assign advance = !res_valid || res_ready;
  assign job_ready = advance;

  always_ff @(posedge clk) begin
    if (load_en) mem[load_addr] <= {load_x, load_y, load_z};
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      rd_a <= mem[job_a];
      rd_b <= mem[job_b];
    end
  end

  always_comb begin
    dx = DW'($signed(rd_b[W3-1 -: CoordBits])) - DW'($signed(rd_a[W3-1 -: CoordBits]));
    dy = DW'($signed(rd_b[2*CoordBits-1 -: CoordBits]))
       - DW'($signed(rd_a[2*CoordBits-1 -: CoordBits]));
    dz = DW'($signed(rd_b[CoordBits-1:0])) - DW'($signed(rd_a[CoordBits-1:0]));
    ax = (axis_select == 2'd3) ? AXIS_Z : axis_select;
    case (ax)
      AXIS_X: begin dax = dx; dr1 = dy; dr2 = dz; end
      AXIS_Y: begin dax = dy; dr1 = dx; dr2 = dz; end
      default: begin dax = dz; dr1 = dx; dr2 = dy; end
    endcase
    m1 = dr1[DW-1] ? DW'(-dr1) : DW'(dr1);
    m2 = dr2[DW-1] ? DW'(-dr2) : DW'(dr2);
    axm = dax[DW-1] ? DW'(-dax) : DW'(dax);
  end

  always_comb begin
    close = !s3_ovf && s3_ax_ok
          && ((LimSqW+1)'(s3_sq1) + (LimSqW+1)'(s3_sq2) <= (LimSqW+1)'(radial_limit_sq));
    found_next = found_count + FoundW'(close);
  end

  // radial component magnitudes wider than 25 bits never pass
  function automatic logic too_big(input logic [DW-1:0] m);
    logic r;
    r = 1'b0;
    for (int i = 25; i < DW; i++) r = r | m[i];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      res_valid <= 1'b0;
      found_count <= '0;
    end else if (advance) begin
      s1_v <= job_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      res_valid <= s3_v;
      if (s3_v) found_count <= s3_l ? '0 : found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_a <= job_a; s1_b <= job_b; s1_l <= job_last;
      s2_a <= s1_a; s2_b <= s1_b; s2_l <= s1_l;
      s2_m1 <= MW'(m1);
      s2_m2 <= MW'(m2);
      s2_axd <= axm;
      s2_ovf <= too_big(m1) | too_big(m2);
      s3_a <= s2_a; s3_b <= s2_b; s3_l <= s2_l;
      s3_sq1 <= s2_m1 * s2_m1;
      s3_sq2 <= s2_m2 * s2_m2;
      s3_ovf <= s2_ovf;
      s3_ax_ok <= (AxLimW+1)'(s2_axd) <= (AxLimW+1)'(axial_limit);
      res_first_index <= SlotW'(s3_a);
      res_second_index <= SlotW'(s3_b);
      res_is_close <= close;
      res_last_pair <= s3_l;
      res_close_count <= found_next[CloseW-1:0];
    end
  end
endmodule

[rtl/cylinder_cutoff_pair_scan_core.sv]
// Cylinder cutoff pair scan core. Load requests write one atom position into
// the dual-read position store; evaluate requests take the next pair of the
// scan and give one result, with one pair per cycle sustained while results
// are taken, set by the two store read ports and the squaring stage. A load
// waits until every queued pair has read the store. The front end walks the
// scan counters; a four-entry job queue decouples it from the back end
// pipeline. A write to a mapped configuration register restarts the scan.
module cylinder_cutoff_pair_scan_core import ccps_pkg::*; #(
  parameter int MaxAtoms = MaxAtomsDefault,
  parameter int CoordBits = CoordBitsDefault
) (
  input  logic clk,
  input  logic rst,
  ccps_in_if.sink in_ch,
  ccps_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);
  localparam int AddrW = $clog2(MaxAtoms);
  localparam int JW = 2 * AddrW + 1;

  logic [1:0] list_mode, axis_select;
  logic [CountW-1:0] first_count, second_count;
  logic [LimSqW-1:0] radial_limit_sq;
  logic [AxLimW-1:0] axial_limit;
  logic restart;
  logic [1:0] mode_new;
  logic restart_tri;

  assign restart = cfg_we && (cfg_index <= REG_AX_LIM);

  // scan start depends on the mode in force after this edge
  always_comb begin
    mode_new = list_mode;
    if (cfg_we && cfg_index == REG_LIST_MODE) mode_new = cfg_data[1:0];
    restart_tri = rst || ((mode_new != MODE_CROSS) && (mode_new != MODE_INDEX));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_mode <= MODE_TRI;
      first_count <= '0;
      second_count <= '0;
      axis_select <= AXIS_Z;
      radial_limit_sq <= '0;
      axial_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIST_MODE:  list_mode <= cfg_data[1:0];
        REG_FIRST_CNT:  first_count <= cfg_data[CountW-1:0];
        REG_SECOND_CNT: second_count <= cfg_data[CountW-1:0];
        REG_AXIS:       axis_select <= cfg_data[1:0];
        REG_RAD_LIM:    radial_limit_sq <= cfg_data[LimSqW-1:0];
        REG_AX_LIM:     axial_limit <= cfg_data[AxLimW-1:0];
        default: ;
      endcase
    end
  end

  logic load_en, fj_valid, fj_ready, fj_last;
  logic [AddrW-1:0] load_addr, fj_a, fj_b;
  logic bj_valid, bj_ready;
  logic [JW-1:0] bj_data;

  ccps_front #(.MaxAtoms(MaxAtoms), .AddrW(AddrW)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.op), .in_slot(in_ch.slot),
    .list_mode, .first_count, .second_count, .restart, .restart_tri,
    .queue_empty(!bj_valid),
    .load_en, .load_addr,
    .job_valid(fj_valid), .job_ready(fj_ready),
    .job_a(fj_a), .job_b(fj_b), .job_last(fj_last)
  );

  ccps_queue #(.Width(JW), .Depth(4)) u_queue (
    .clk, .rst(rst || restart),
    .wr_valid(fj_valid), .wr_ready(fj_ready),
    .wr_data({fj_a, fj_b, fj_last}),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj_data)
  );

  ccps_back #(.MaxAtoms(MaxAtoms), .CoordBits(CoordBits), .AddrW(AddrW)) u_back (
    .clk, .rst,
    .load_en, .load_addr,
    .load_x(CoordBits'(in_ch.pos_x)), .load_y(CoordBits'(in_ch.pos_y)),
    .load_z(CoordBits'(in_ch.pos_z)),
    .axis_select, .radial_limit_sq, .axial_limit, .restart,
    .job_valid(bj_valid), .job_ready(bj_ready),
    .job_a(bj_data[JW-1 -: AddrW]), .job_b(bj_data[1 +: AddrW]),
    .job_last(bj_data[0]),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res_first_index(out_ch.first_index), .res_second_index(out_ch.second_index),
    .res_is_close(out_ch.is_close), .res_last_pair(out_ch.last_pair),
    .res_close_count(out_ch.close_count)
  );
endmodule

[rtl/ccps_checker.sv]
// port-level checks for the pair scan core, bound to the top level
// depends on ccps_pkg and ccps_if
module ccps_checker import ccps_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [CloseW-1:0] out_count,
  input logic out_close
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_stable_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_close) && $stable(out_last))
    else $error("result flags moved");
  a_stable_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_count)) else $error("count moved");
  a_ready_rst: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");
  a_in_ready_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_ready || !in_valid) else $error("request blocked after reset");
endmodule

bind cylinder_cutoff_pair_scan_core ccps_checker u_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_last(out_ch.last_pair), .out_count(out_ch.close_count),
  .out_close(out_ch.is_close)
);

[bench/ccps_pair_checker.sv]
// pair scan checker: watches the request, result and register ports of the core,
// predicts each evaluated pair and compares it field by field
// depends on ccps_pkg and the channel interfaces in ccps_if
module ccps_pair_checker import ccps_pkg::*; (
  input  logic clk,
  input  logic rst,
  ccps_in_if in_ch,
  ccps_out_if out_ch,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int errors,
  output int pending
);
  localparam int Atoms = MaxAtomsDefault;

  typedef struct packed {
    logic [SlotW-1:0] first_index;
    logic [SlotW-1:0] second_index;
    logic is_close;
    logic last_pair;
    logic [CloseW-1:0] close_count;
  } pair_result_t;

  pair_result_t pair_results_q[$];

  logic [1:0] mode_r, axis_r;
  logic [CountW-1:0] first_r, second_r;
  logic [LimSqW-1:0] rad_lim_r;
  logic [AxLimW-1:0] ax_lim_r;
  logic signed [CoordBitsDefault-1:0] pos_x_mem [Atoms];
  logic signed [CoordBitsDefault-1:0] pos_y_mem [Atoms];
  logic signed [CoordBitsDefault-1:0] pos_z_mem [Atoms];
  int unsigned outer_idx, inner_idx;
  logic [FoundW-1:0] found;

  function automatic logic [1:0] scan_mode();
    return (mode_r == MODE_CROSS || mode_r == MODE_INDEX) ? mode_r : MODE_TRI;
  endfunction

  function automatic int unsigned list_a();
    return (first_r > Atoms) ? Atoms : first_r;
  endfunction

  function automatic int unsigned list_b();
    int unsigned room;
    room = Atoms - list_a();
    return (second_r > room) ? room : second_r;
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic restart_scan();
    outer_idx = 0;
    inner_idx = (scan_mode() == MODE_TRI) ? 1 : 0;
    found = '0;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic predict_pair();
    int unsigned n0, n1, a, b, pairs;
    logic last, close;
    logic signed [63:0] dx, dy, dz, rd1, rd2, axd;
    logic [63:0] m1, m2, ma;
    pair_result_t r;
    n0 = list_a();
    n1 = list_b();
    case (scan_mode())
      MODE_CROSS: begin
        if (n0 == 0 || n1 == 0) return;
        a = outer_idx;
        b = n0 + inner_idx;
        last = (outer_idx == n0 - 1) && (inner_idx == n1 - 1);
      end
      MODE_INDEX: begin
        pairs = (n0 < n1) ? n0 : n1;
        if (pairs == 0) return;
        a = outer_idx;
        b = n0 + outer_idx;
        last = (outer_idx == pairs - 1);
      end
      default: begin
        if (n0 < 2) return;
        a = outer_idx;
        b = inner_idx;
        last = (a == n0 - 2) && (b == n0 - 1);
      end
    endcase
    a = a % Atoms;
    b = b % Atoms;
    dx = 64'(pos_x_mem[b]) - 64'(pos_x_mem[a]);
    dy = 64'(pos_y_mem[b]) - 64'(pos_y_mem[a]);
    dz = 64'(pos_z_mem[b]) - 64'(pos_z_mem[a]);
    // unused axis code falls back to z
    if (axis_r == AXIS_X) begin
      axd = dx; rd1 = dy; rd2 = dz;
    end else if (axis_r == AXIS_Y) begin
      axd = dy; rd1 = dx; rd2 = dz;
    end else begin
      axd = dz; rd1 = dx; rd2 = dy;
    end
    m1 = magnitude(rd1);
    m2 = magnitude(rd2);
    ma = magnitude(axd);
    if (m1 >= (64'd1 << 25) || m2 >= (64'd1 << 25))
      close = 1'b0;
    else
      close = (m1 * m1 + m2 * m2 <= 64'(rad_lim_r)) && (ma <= 64'(ax_lim_r));
    if (close) found = found + 1'b1;
    r.first_index = a[SlotW-1:0];
    r.second_index = b[SlotW-1:0];
    r.is_close = close;
    r.last_pair = last;
    r.close_count = found[CloseW-1:0];
    pair_results_q.insert(pair_results_q.size(), r);
    if (last) begin
      restart_scan();
    end else if (scan_mode() == MODE_TRI) begin
      inner_idx++;
      if (inner_idx >= n0) begin
        outer_idx++;
        inner_idx = outer_idx + 1;
      end
    end else if (scan_mode() == MODE_CROSS) begin
      inner_idx++;
      if (inner_idx >= n1) begin
        inner_idx = 0;
        outer_idx++;
      end
    end else begin
      outer_idx++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_r = MODE_TRI;
      axis_r = AXIS_Z;
      first_r = '0;
      second_r = '0;
      rad_lim_r = '0;
      ax_lim_r = '0;
      errors = 0;
      pair_results_q.delete();
      restart_scan();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pair_results_q.size() == 0) begin
          $display("%0t: result with no pair outstanding", $realtime);
          errors++;
        end else begin
          pair_result_t w;
          w = pair_results_q.pop_front();
          if (out_ch.first_index !== w.first_index)
            report("first_index", out_ch.first_index, w.first_index);
          if (out_ch.second_index !== w.second_index)
            report("second_index", out_ch.second_index, w.second_index);
          if (out_ch.is_close !== w.is_close)
            report("is_close", out_ch.is_close, w.is_close);
          if (out_ch.last_pair !== w.last_pair)
            report("last_pair", out_ch.last_pair, w.last_pair);
          if (out_ch.close_count !== w.close_count)
            report("close_count", out_ch.close_count, w.close_count);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_LOAD) begin
          pos_x_mem[in_ch.slot] = in_ch.pos_x;
          pos_y_mem[in_ch.slot] = in_ch.pos_y;
          pos_z_mem[in_ch.slot] = in_ch.pos_z;
        end else begin
          predict_pair();
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LIST_MODE:  mode_r = cfg_data[1:0];
          REG_FIRST_CNT:  first_r = cfg_data[CountW-1:0];
          REG_SECOND_CNT: second_r = cfg_data[CountW-1:0];
          REG_AXIS:       axis_r = cfg_data[1:0];
          REG_RAD_LIM:    rad_lim_r = cfg_data[LimSqW-1:0];
          REG_AX_LIM:     ax_lim_r = cfg_data[AxLimW-1:0];
          default: ;
        endcase
        // writes to unmapped indexes leave the scan where it is
        if (cfg_index inside {REG_LIST_MODE, REG_FIRST_CNT, REG_SECOND_CNT, REG_AXIS,
                              REG_RAD_LIM, REG_AX_LIM})
          restart_scan();
      end
    end
    pending = pair_results_q.size();
  end
endmodule

[bench/cylinder_cutoff_pair_scan_core_test.sv]
// testbench top for the cylinder cutoff pair scan core: drives loads, evaluates and
// register writes with random gaps and stalls; verdict comes from ccps_pair_checker
// depends on ccps_pkg, ccps_if, the core and ccps_pair_checker
module cylinder_cutoff_pair_scan_core_test;
  import ccps_pkg::*;

  localparam int Atoms = MaxAtomsDefault;
  localparam int DrainCycles = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int errors, pending;
  bit quiet;
  bit written [Atoms];
  int coord_span;
  int requests;
  int n0_eff, n1_eff;

  ccps_in_if in_ch (clk);
  ccps_out_if out_ch (clk);

  cylinder_cutoff_pair_scan_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ccps_pair_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always #5 clk = ~clk;

  initial begin
    #4000000;
    $display("cylinder_cutoff_pair_scan_core_test failed");
    $finish;
  end

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) hold = quiet ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      out_ch.ready <= (hold == 0);
      if (hold > 0) hold--;
    end
  end

  function automatic logic [23:0] rand_coord();
    if (coord_span == 0) return 24'($urandom);
    return 24'($urandom_range(0, 2 * coord_span) - coord_span);
  endfunction

  // called and returns right after a falling edge
  task automatic send(op_t op, logic [SlotW-1:0] slot, logic [23:0] x, y, z);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.slot <= slot;
    in_ch.pos_x <= x;
    in_ch.pos_y <= y;
    in_ch.pos_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (op == OP_LOAD) written[slot] = 1'b1;
    requests++;
  endtask

  task automatic load(int s, logic [23:0] x, y, z);
    send(OP_LOAD, s[SlotW-1:0], x, y, z);
  endtask

  task automatic evaluate();
    send(OP_EVAL, SlotW'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic fill_slots(int lo, int hi);
    for (int s = lo; s < hi && s < Atoms; s++)
      if (!written[s]) load(s, rand_coord(), rand_coord(), rand_coord());
  endtask

  // idle the request side until every pair result is back, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic reg_write(cfg_reg_t idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic configure(logic [1:0] mode, int n0, int n1, logic [1:0] axis,
                           logic [LimSqW-1:0] rad, logic [AxLimW-1:0] axl);
    settle();
    reg_write(REG_LIST_MODE, CfgDataW'(mode));
    reg_write(REG_FIRST_CNT, CfgDataW'(n0));
    reg_write(REG_SECOND_CNT, CfgDataW'(n1));
    reg_write(REG_AXIS, CfgDataW'(axis));
    reg_write(REG_RAD_LIM, CfgDataW'(rad));
    reg_write(REG_AX_LIM, CfgDataW'(axl));
    cfg_we <= 1'b0;
    n0_eff = (n0 > Atoms) ? Atoms : n0;
    n1_eff = (n1 > Atoms - n0_eff) ? Atoms - n0_eff : n1;
  endtask

  function automatic int pick_count();
    int opts [4] = '{1024, 2047, 1000, 1023};
    if ($urandom_range(0, 5) == 0) return opts[$urandom_range(0, 3)];
    return $urandom_range(0, 10);
  endfunction

  initial begin
    int k, lo_n;
    logic [LimSqW-1:0] rad;
    logic [AxLimW-1:0] axl;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.slot = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    cfg_we = 1'b0;
    cfg_index = REG_LIST_MODE;
    cfg_data = '0;
    quiet = 1'b1;
    requests = 0;
    coord_span = 1 << 10;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: coordinate extremes, wrap of a small triangle, unmapped indexes,
    // unused mode and axis codes, empty scan
    load(0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    load(1, 24'h800000, 24'h800000, 24'h800000);
    load(2, 24'h000000, 24'h000000, 24'h000000);
    load(3, 24'h7FFFFF, 24'h800000, 24'h000001);
    configure(MODE_TRI, 4, 0, AXIS_Z, '1, '1);
    repeat (7) evaluate();
    settle();
    reg_write(cfg_reg_t'(3'd6), '1);
    reg_write(cfg_reg_t'(3'd7), '0);
    cfg_we <= 1'b0;
    repeat (2) evaluate();
    configure(2'd3, 3, 0, 2'd3, '0, '0);
    repeat (3) evaluate();
    configure(MODE_CROSS, 2, 2, AXIS_X, 50'd1 << 48, 24'd1 << 23);
    repeat (5) evaluate();
    configure(MODE_INDEX, 1, 0, AXIS_Y, '1, '1);
    evaluate();

    // random phases of well-formed scans with stray loads mixed in
    quiet = 1'b0;
    while (requests < 600) begin
      case ($urandom_range(0, 2))
        0: coord_span = 1 << 6;
        1: coord_span = 1 << 12;
        default: coord_span = 0;
      endcase
      k = $urandom_range(15, 45);
      if (coord_span == 0) begin
        rad = LimSqW'({$urandom, $urandom});
        axl = 24'($urandom);
      end else begin
        rad = LimSqW'($urandom_range(0, 2 * coord_span))
            * LimSqW'($urandom_range(0, 2 * coord_span));
        axl = 24'($urandom_range(0, 2 * coord_span));
      end
      if ($urandom_range(0, 7) == 0) rad = '0;
      if ($urandom_range(0, 7) == 0) rad = '1;
      if ($urandom_range(0, 7) == 0) axl = '0;
      if ($urandom_range(0, 7) == 0) axl = '1;
      configure(2'($urandom_range(0, 3)), pick_count(), pick_count(),
                2'($urandom_range(0, 3)), rad, axl);
      quiet = ($urandom_range(0, 3) == 0);
      lo_n = (n0_eff < k + 2) ? n0_eff : k + 2;
      fill_slots(0, lo_n);
      fill_slots(n0_eff, n0_eff + ((n1_eff < k + 1) ? n1_eff : k + 1));
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0)
          load($urandom_range(0, Atoms - 1), rand_coord(), rand_coord(), rand_coord());
        else
          evaluate();
        if (i == k / 2 && $urandom_range(0, 3) == 0) begin
          in_ch.valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end

    settle();
    if (errors == 0)
      $display("cylinder_cutoff_pair_scan_core_test passed");
    else
      $display("cylinder_cutoff_pair_scan_core_test failed");
    $finish;
  end
endmodule

[files.f]
rtl/ccps_pkg.sv
rtl/ccps_if.sv
rtl/ccps_front.sv
rtl/ccps_queue.sv
rtl/ccps_back.sv
rtl/cylinder_cutoff_pair_scan_core.sv
rtl/ccps_checker.sv
bench/ccps_pair_checker.sv
bench/cylinder_cutoff_pair_scan_core_test.sv
